@@ design/mm4_pkg.sv @@
package mm4_pkg;

  // Defaults for the top-level parameters
  localparam int DIM_DEF        = 4;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port widths and number format
  localparam int INDEX_W   = 4;
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;

  // Controller to datapath commands, one set per cycle
  typedef struct packed {
    logic wr_en;       // store the accepted load request
    logic mac_en;      // read one operand pair and start a multiply
    logic acc_first;   // first term of a dot product
    logic acc_last;    // last term of a dot product
    logic final_cell;  // last term of the last product element
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;   // some term or result still in flight
  } status_t;

endpackage

@@ design/matrix_multiply_4x4.sv @@
// Load request without in_load_done: busy stays low, so loads may issue back to back.
// Multiply: busy rises after the request with in_load_done set and stays high until
// the last result has left, one multiply-accumulate per cycle on a single shared MAC.
// Results: DIM*DIM strobes, one per product element, never stalled;
// busy drops once the drain state sees the pipeline empty after the last strobe.
// Reset: synchronous, active low; control clears, matrix contents are undefined.
module matrix_multiply_4x4 #(
  parameter int DIM        = mm4_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_matrix_sel,
  input  logic [mm4_pkg::INDEX_W-1:0]        in_elem_index,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  in_element_value,
  input  logic                               in_load_done,
  output logic                               out_valid,
  output logic [mm4_pkg::INDEX_W-1:0]        out_result_index,
  output logic signed [mm4_pkg::ELEM_W-1:0]  out_result_value,
  output logic                               out_saturated,
  output logic                               out_last_result
);

  localparam int IDX_W = $clog2(DIM*DIM);

  mm4_pkg::cmd_t    cmd;
  mm4_pkg::status_t status;
  logic [IDX_W-1:0] a_addr, b_addr, elem_idx;

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .load_done (in_load_done),
    .status    (status),
    .cmd       (cmd),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .elem_idx  (elem_idx),
    .busy      (busy)
  );

  mm4_dpath #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .elem_idx  (elem_idx),
    .wr_sel    (in_matrix_sel),
    .wr_index  (in_elem_index),
    .wr_value  (in_element_value),
    .status    (status),
    .res_valid (out_valid),
    .res_index (out_result_index),
    .res_value (out_result_value),
    .res_sat   (out_saturated),
    .res_last  (out_last_result)
  );

endmodule

@@ design/mm4_ctrl.sv @@
module mm4_ctrl #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          load_done,
  input  mm4_pkg::status_t              status,
  output mm4_pkg::cmd_t                 cmd,
  output logic [$clog2(DIM*DIM)-1:0]    a_addr,
  output logic [$clog2(DIM*DIM)-1:0]    b_addr,
  output logic [$clog2(DIM*DIM)-1:0]    elem_idx,
  output logic                          busy
);

  localparam int IDX_W = $clog2(DIM*DIM);
  localparam int CNT_W = $clog2(DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] cell_r, cell_nxt;
  logic             k_end, col_end, row_end;

  assign k_end   = (k_r == CNT_W'(DIM - 1));
  assign col_end = (col_r == CNT_W'(DIM - 1));
  assign row_end = (row_r == CNT_W'(DIM - 1));

  assign a_addr   = IDX_W'(row_r) * IDX_W'(DIM) + IDX_W'(k_r);
  assign b_addr   = IDX_W'(k_r) * IDX_W'(DIM) + IDX_W'(col_r);
  assign elem_idx = cell_r;
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    k_nxt          = k_r;
    cell_nxt       = cell_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_en = start;
        if (start && load_done) begin
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
          cell_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.mac_en     = 1'b1;
        cmd.acc_first  = (k_r == '0);
        cmd.acc_last   = k_end;
        cmd.final_cell = k_end && col_end && row_end;
        if (k_end) begin
          k_nxt    = '0;
          cell_nxt = cell_r + 1'b1;
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            if (row_end) begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // hold off new requests until the last result has left
        if (!status.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
      cell_r  <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
      cell_r  <= cell_nxt;
    end
  end

endmodule

@@ design/mm4_dpath.sv @@
module mm4_dpath #(
  parameter int DIM        = mm4_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mm4_pkg::cmd_t                      cmd,
  input  logic [$clog2(DIM*DIM)-1:0]         a_addr,
  input  logic [$clog2(DIM*DIM)-1:0]         b_addr,
  input  logic [$clog2(DIM*DIM)-1:0]         elem_idx,
  input  logic                               wr_sel,
  input  logic [mm4_pkg::INDEX_W-1:0]        wr_index,
  input  logic [mm4_pkg::ELEM_W-1:0]         wr_value,
  output mm4_pkg::status_t                   status,
  output logic                               res_valid,
  output logic [mm4_pkg::INDEX_W-1:0]        res_index,
  output logic signed [mm4_pkg::ELEM_W-1:0]  res_value,
  output logic                               res_sat,
  output logic                               res_last
);

  localparam int CELLS  = DIM * DIM;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CMP_W  = ((IDX_W > mm4_pkg::INDEX_W) ? IDX_W : mm4_pkg::INDEX_W) + 1;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int TOP_W  = ACC_W - DATA_WIDTH + 1;
  localparam int OUT_IW = mm4_pkg::INDEX_W;
  localparam int OUT_VW = mm4_pkg::ELEM_W;

  logic [DATA_WIDTH-1:0] left_mem  [CELLS];
  logic [DATA_WIDTH-1:0] right_mem [CELLS];

  logic [CMP_W-1:0] wr_ext;
  logic             wr_ok;
  logic [IDX_W-1:0] wr_addr;

  logic signed [DATA_WIDTH-1:0] a_q_r, b_q_r;
  logic                         s1_v_r, s1_first_r, s1_last_r, s1_final_r;
  logic [IDX_W-1:0]             s1_cell_r;

  logic signed [PROD_W-1:0]     prod_r;
  logic                         s2_v_r, s2_first_r, s2_last_r, s2_final_r;
  logic [IDX_W-1:0]             s2_cell_r;

  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic                         s3_v_r, s3_final_r;
  logic [IDX_W-1:0]             s3_cell_r;

  logic signed [ACC_W-1:0]      shifted;
  logic [TOP_W-1:0]             top_bits;
  logic                         fits;
  logic signed [DATA_WIDTH-1:0] clamp_val;

  logic                         out_v_r, out_sat_r, out_last_r;
  logic [OUT_IW-1:0]            out_idx_r;
  logic signed [DATA_WIDTH-1:0] out_val_r;

  // Load port: an index past the matrix writes nothing
  assign wr_ext  = CMP_W'(wr_index);
  assign wr_ok   = cmd.wr_en && (wr_ext < CMP_W'(CELLS));
  assign wr_addr = wr_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok && !wr_sel) begin
      left_mem[wr_addr] <= wr_value[DATA_WIDTH-1:0];
    end
    if (wr_ok && wr_sel) begin
      right_mem[wr_addr] <= wr_value[DATA_WIDTH-1:0];
    end
    a_q_r <= left_mem[a_addr];
    b_q_r <= right_mem[b_addr];
  end

  // Product, accumulate and floor/saturate stages
  assign acc_nxt = s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  assign shifted   = acc_r >>> mm4_pkg::FRAC_BITS;
  assign top_bits  = shifted[ACC_W-1:DATA_WIDTH-1];
  assign fits      = (&top_bits) || !(|top_bits);
  assign clamp_val = acc_r[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                    : {1'b0, {(DATA_WIDTH-1){1'b1}}};

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.acc_first;
    s1_last_r  <= cmd.acc_last;
    s1_final_r <= cmd.final_cell;
    s1_cell_r  <= elem_idx;
    prod_r     <= a_q_r * b_q_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_final_r <= s1_final_r;
    s2_cell_r  <= s1_cell_r;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    s3_final_r <= s2_final_r;
    s3_cell_r  <= s2_cell_r;
    out_val_r  <= fits ? shifted[DATA_WIDTH-1:0] : clamp_val;
    out_sat_r  <= !fits;
    out_last_r <= s3_final_r;
    out_idx_r  <= OUT_IW'(s3_cell_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= cmd.mac_en;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r && s2_last_r;
      out_v_r <= s3_v_r;
    end
  end

  assign status.pipe_busy = s1_v_r || s2_v_r || s3_v_r || out_v_r;

  assign res_valid = out_v_r;
  assign res_index = out_idx_r;
  assign res_value = OUT_VW'(out_val_r);
  assign res_sat   = out_sat_r && out_v_r;
  assign res_last  = out_last_r && out_v_r;

endmodule

@@ design/mm4_checker.sv @@
module mm4_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_load_done,
  input logic out_valid,
  input logic out_last_result
);

  // results only come out during a multiply
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  // the final result is not directly followed by another strobe
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !out_valid)
    else $error("result strobe after the final result");

  // a plain load request does not start a multiply
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_load_done |=> !busy)
    else $error("busy after an ordinary load request");

  // the closing load request starts a multiply
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_load_done |=> busy && !out_valid)
    else $error("multiply did not start after the closing load request");

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_load_done    (in_load_done),
  .out_valid       (out_valid),
  .out_last_result (out_last_result)
);

@@ sim/matrix_product_checker.sv @@
`timescale 1ns / 100ps

module matrix_product_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_matrix_sel,
  input  logic [mm4_pkg::INDEX_W-1:0]        in_elem_index,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  in_element_value,
  input  logic                               in_load_done,
  input  logic                               out_valid,
  input  logic [mm4_pkg::INDEX_W-1:0]        out_result_index,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  out_result_value,
  input  logic                               out_saturated,
  input  logic                               out_last_result,
  output int                                 mismatch_count,
  output int                                 cells_pending
);

  localparam int DIM       = mm4_pkg::DIM_DEF;
  localparam int CELLS     = DIM * DIM;
  localparam int SUM_W     = 2 * mm4_pkg::ELEM_W + 2;
  localparam int PRINT_CAP = 100;

  localparam logic signed [SUM_W-1:0] CLAMP_HI = 66'sd2147483647;
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -66'sd2147483648;

  typedef struct packed {
    logic [mm4_pkg::INDEX_W-1:0]       index;
    logic signed [mm4_pkg::ELEM_W-1:0] value;
    logic                              sat;
    logic                              last;
  } product_cell_t;

  logic signed [mm4_pkg::ELEM_W-1:0] left_store  [CELLS];
  logic signed [mm4_pkg::ELEM_W-1:0] right_store [CELLS];
  product_cell_t                     awaited_cells [$];
  int                                mismatches = 0;
  int                                pending    = 0;

  assign mismatch_count = mismatches;
  assign cells_pending  = pending;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Exact dot product, floored from Q32.32 to Q16.16, then clamped.
  function automatic product_cell_t product_cell(input int unsigned pos);
    logic signed [SUM_W-1:0] dot_sum;
    logic signed [SUM_W-1:0] floored;
    longint                  term;
    int unsigned             row;
    int unsigned             col;
    int unsigned             k;
    product_cell_t           res;
    row     = pos / DIM;
    col     = pos % DIM;
    dot_sum = '0;
    for (k = 0; k < DIM; k++) begin
      term    = longint'(left_store[row * DIM + k]) * longint'(right_store[k * DIM + col]);
      dot_sum = dot_sum + term;
    end
    floored = dot_sum >>> mm4_pkg::FRAC_BITS;
    if (floored > CLAMP_HI) begin
      res.value = CLAMP_HI[mm4_pkg::ELEM_W-1:0];
      res.sat   = 1'b1;
    end else if (floored < CLAMP_LO) begin
      res.value = CLAMP_LO[mm4_pkg::ELEM_W-1:0];
      res.sat   = 1'b1;
    end else begin
      res.value = floored[mm4_pkg::ELEM_W-1:0];
      res.sat   = 1'b0;
    end
    res.index = pos[mm4_pkg::INDEX_W-1:0];
    res.last  = (pos == CELLS - 1);
    return res;
  endfunction

  always @(posedge clk) begin
    product_cell_t want;
    int unsigned   pos;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected result, index %0d value %h",
                                    out_result_index, out_result_value));
        end else begin
          want = awaited_cells.pop_front();
          if (out_result_index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d",
                                      out_result_index, want.index));
          if (out_result_value !== want.value)
            report_mismatch($sformatf("cell %0d value got %h want %h",
                                      want.index, out_result_value, want.value));
          if (out_saturated !== want.sat)
            report_mismatch($sformatf("cell %0d saturated got %b want %b",
                                      want.index, out_saturated, want.sat));
          if (out_last_result !== want.last)
            report_mismatch($sformatf("cell %0d last got %b want %b",
                                      want.index, out_last_result, want.last));
        end
      end
      if (start && !busy) begin
        if (in_elem_index < CELLS) begin
          if (in_matrix_sel)
            right_store[in_elem_index] = in_element_value;
          else
            left_store[in_elem_index] = in_element_value;
        end
        if (in_load_done) begin
          for (pos = 0; pos < CELLS; pos++)
            awaited_cells.push_back(product_cell(pos));
        end
      end
      pending <= awaited_cells.size();
    end
  end

endmodule

@@ sim/tb_matrix_multiply_4x4.sv @@
`timescale 1ns / 100ps

module tb_matrix_multiply_4x4;

  localparam int DIM          = mm4_pkg::DIM_DEF;
  localparam int CELLS        = DIM * DIM;
  localparam int RANDOM_LOADS = 93;
  localparam int DRAIN_CYCLES = DIM * DIM * DIM + 16;

  typedef enum int unsigned {VAL_FULL, VAL_UNIT, VAL_WIDE, VAL_CORNER} value_mode_t;
  typedef enum int unsigned {BURST_UPDATE, BURST_RELOAD, BURST_NOISE} burst_kind_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic                              in_matrix_sel;
  logic [mm4_pkg::INDEX_W-1:0]       in_elem_index;
  logic signed [mm4_pkg::ELEM_W-1:0] in_element_value;
  logic                              in_load_done;
  logic                              out_valid;
  logic [mm4_pkg::INDEX_W-1:0]       out_result_index;
  logic signed [mm4_pkg::ELEM_W-1:0] out_result_value;
  logic                              out_saturated;
  logic                              out_last_result;
  int                                mismatch_count;
  int                                cells_pending;

  int random_loads = 0;
  int quiet_left   = 0;

  matrix_multiply_4x4 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_matrix_sel    (in_matrix_sel),
    .in_elem_index    (in_elem_index),
    .in_element_value (in_element_value),
    .in_load_done     (in_load_done),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .out_last_result  (out_last_result)
  );

  matrix_product_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_matrix_sel    (in_matrix_sel),
    .in_elem_index    (in_elem_index),
    .in_element_value (in_element_value),
    .in_load_done     (in_load_done),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .out_last_result  (out_last_result),
    .mismatch_count   (mismatch_count),
    .cells_pending    (cells_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [31:0] corner_value(input int unsigned n);
    case (n % 7)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      4: return 32'sh0001_0000;
      5: return 32'shFFFF_0000;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value(input value_mode_t mode);
    logic [31:0] raw;
    raw = $urandom;
    case (mode)
      VAL_UNIT:   return $signed($urandom_range(0, 131072)) - 32'sd65536;
      VAL_WIDE:   return {{8{raw[23]}}, raw[23:0]};
      VAL_CORNER: return corner_value($urandom_range(0, 6));
      default:    return raw;
    endcase
  endfunction

  // Hold the request until the block takes it.
  task automatic send_load(input logic sel, input logic [3:0] idx,
                           input logic signed [31:0] value, input logic done);
    start            <= 1'b1;
    in_matrix_sel    <= sel;
    in_elem_index    <= idx;
    in_element_value <= value;
    in_load_done     <= done;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a random stretch; scramble the idle fields meanwhile.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      len = 0;
    end else if (roll < 5) begin
      quiet_left = $urandom_range(10, 30);
      len = 0;
    end else if (roll < 55) begin
      len = 0;
    end else if (roll < 90) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(8, 40);
    end
    if (len > 0) begin
      start            <= 1'b0;
      in_matrix_sel    <= 1'($urandom);
      in_elem_index    <= 4'($urandom);
      in_element_value <= $urandom;
      in_load_done     <= 1'($urandom);
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic random_burst();
    burst_kind_t  kind;
    value_mode_t  base_mode;
    value_mode_t  mode;
    int unsigned  roll;
    int unsigned  n;
    int unsigned  j;
    int unsigned  offset;
    int unsigned  stride;
    logic         sel;
    roll      = $urandom_range(0, 9);
    kind      = (roll < 6) ? BURST_UPDATE : (roll < 8) ? BURST_RELOAD : BURST_NOISE;
    base_mode = value_mode_t'($urandom_range(0, 3));
    case (kind)
      BURST_RELOAD: begin
        // odd stride over 16 entries visits every one
        sel    = 1'($urandom);
        offset = $urandom_range(0, CELLS - 1);
        stride = 2 * $urandom_range(0, 7) + 1;
        n      = CELLS;
      end
      BURST_NOISE:  n = $urandom_range(1, 4);
      default:      n = $urandom_range(1, 6);
    endcase
    for (j = 0; j < n; j++) begin
      mode = ($urandom_range(0, 3) == 0) ? value_mode_t'($urandom_range(0, 3)) : base_mode;
      if (kind == BURST_RELOAD)
        send_load(sel, 4'((offset + j * stride) % CELLS), pick_value(mode), j == n - 1);
      else
        send_load(1'($urandom), 4'($urandom), pick_value(mode),
                  (kind == BURST_UPDATE) && (j == n - 1));
      random_loads++;
      idle_gap();
    end
  endtask

  initial begin
    int unsigned i;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_matrix_sel    <= 1'b0;
    in_elem_index    <= '0;
    in_element_value <= '0;
    in_load_done     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both matrices with corner values; the last entry triggers a multiply.
    for (i = 0; i < CELLS; i++) begin
      send_load(1'b0, 4'(i), corner_value(i), 1'b0);
      idle_gap();
    end
    for (i = 0; i < CELLS; i++) begin
      send_load(1'b1, 4'(i), corner_value(3 * i + 1), i == CELLS - 1);
      idle_gap();
    end
    // Single-entry overwrites; all but the one to left entry 5 multiply again on retained contents.
    send_load(1'b0, 4'd0, 32'sh0001_0000, 1'b1);
    idle_gap();
    send_load(1'b1, 4'd15, 32'sh8000_0000, 1'b1);
    idle_gap();
    send_load(1'b0, 4'd5, 32'shFFFF_FFFF, 1'b0);
    idle_gap();
    send_load(1'b1, 4'd5, 32'sh0000_0001, 1'b1);
    idle_gap();
    send_load(1'b1, 4'd5, 32'sh0000_0001, 1'b1);
    idle_gap();

    while (random_loads < RANDOM_LOADS)
      random_burst();

    start <= 1'b0;
    @(posedge clk);
    wait (cells_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cells_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
